// File: src/c3mb_pkg.sv
// Shared types and constants for the 3x3 mirrored-border convolution filter.
`timescale 1ns / 1ps
package c3mb_pkg;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int KDIM           = 3;
	localparam int NTAP           = KDIM * KDIM;
	localparam int CH_W           = 8;
	localparam int NCH            = 3;
	localparam int PIX_W          = CH_W * NCH;
	localparam int COEF_W         = 16;
	localparam int ROW_COEF_W     = COEF_W * KDIM;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd5;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [NTAP-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		win_t win;
		logic color;
		logic frame_end;
		logic run_end;
	} conv_req_t;
endpackage

// File: src/c3mb_mac.sv
// Multiply-accumulate pipeline: 3x3 window times Q8.8 kernel, clamp, output register.
`timescale 1ns / 1ps
module c3mb_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [c3mb_pkg::ROW_COEF_W-1:0]      coef_top,
	input  logic [c3mb_pkg::ROW_COEF_W-1:0]      coef_mid,
	input  logic [c3mb_pkg::ROW_COEF_W-1:0]      coef_bot,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  c3mb_pkg::conv_req_t                  req,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [c3mb_pkg::PIX_W-1:0]           m_axis_tdata,
	output logic                                 m_axis_tlast,
	output logic [0:0]                           m_axis_tuser
);
	localparam int PW = c3mb_pkg::CH_W + c3mb_pkg::COEF_W + 1;
	localparam int SW = PW + 4;

	c3mb_pkg::conv_req_t req_s1;
	logic                v_s1, v_s2, v_s3;
	logic signed [PW-1:0] prod_s2 [c3mb_pkg::NCH][c3mb_pkg::NTAP];
	logic                color_s2, fend_s2, rend_s2;
	logic [c3mb_pkg::PIX_W-1:0] data_s3;
	logic                fend_s3, rend_s3;
	logic                rdy_s1, rdy_s2, rdy_s3;
	logic [c3mb_pkg::ROW_COEF_W-1:0] rows [c3mb_pkg::KDIM];
	logic signed [PW-1:0] prod [c3mb_pkg::NCH][c3mb_pkg::NTAP];
	logic signed [SW-1:0] sum;
	logic [c3mb_pkg::PIX_W-1:0] res;

	assign rows[0] = coef_top;
	assign rows[1] = coef_mid;
	assign rows[2] = coef_bot;

	assign rdy_s3    = !v_s3 || m_axis_tready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	always_comb begin
		for (int ch = 0; ch < c3mb_pkg::NCH; ch++) begin
			for (int r = 0; r < c3mb_pkg::KDIM; r++) begin
				for (int c = 0; c < c3mb_pkg::KDIM; c++) begin
					prod[ch][r*c3mb_pkg::KDIM+c] =
						$signed({1'b0, req_s1.win[r*c3mb_pkg::KDIM+c][c3mb_pkg::CH_W*ch +: c3mb_pkg::CH_W]})
						* $signed(rows[r][c3mb_pkg::COEF_W*c +: c3mb_pkg::COEF_W]);
				end
			end
		end
	end

	always_comb begin
		res = '0;
		for (int ch = 0; ch < c3mb_pkg::NCH; ch++) begin
			sum = '0;
			for (int i = 0; i < c3mb_pkg::NTAP; i++) begin
				sum = sum + SW'(prod_s2[ch][i]);
			end
			// drop fraction, clamp to a byte; gray mode zeroes the upper channels
			if (sum[SW-1] || (ch != 0 && !color_s2)) begin
				res[c3mb_pkg::CH_W*ch +: c3mb_pkg::CH_W] = '0;
			end else if (|sum[SW-2:16]) begin
				res[c3mb_pkg::CH_W*ch +: c3mb_pkg::CH_W] = '1;
			end else begin
				res[c3mb_pkg::CH_W*ch +: c3mb_pkg::CH_W] = sum[15:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) req_s1 <= req;
		if (rdy_s2 && v_s1) begin
			prod_s2  <= prod;
			color_s2 <= req_s1.color;
			fend_s2  <= req_s1.frame_end;
			rend_s2  <= req_s1.run_end;
		end
		if (rdy_s3 && v_s2) begin
			data_s3 <= res;
			fend_s3 <= fend_s2;
			rend_s3 <= rend_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = data_s3;
	assign m_axis_tlast  = rend_s3;
	assign m_axis_tuser  = fend_s3;
endmodule

// File: src/conv3x3_mirror_border_filter.sv
// Top level: frame control, line stores, 3x3 window and the kernel pipeline.
//
//  channel   direction  payload
//  s_axis    in         tdata: chan_a, chan_b, chan_c (8 bits each)
//  m_axis    out        tdata: res_a, res_b, res_c; tlast: run_end; tuser: frame_end
//  cfg       in         cfg_index (register), cfg_data (48 bits)
//
// One pixel per clock unless the output stalls. A row-end pixel that completes two
// results holds the input for a second step, since the kernel pipeline takes one window
// per clock. Input to result runs through the line store read, window, products, and sum
// and clamp registers. Reset clears counters, window and pending-row state; line stores
// are not cleared. m_axis_tready low backs up stage by stage to s_axis.
`timescale 1ns / 1ps
module conv3x3_mirror_border_filter #(
	parameter int MAX_WIDTH  = c3mb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c3mb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [c3mb_pkg::PIX_W-1:0]           s_axis_tdata,  // chan_a, chan_b, chan_c
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [c3mb_pkg::PIX_W-1:0]           m_axis_tdata,  // res_a, res_b, res_c
	output logic                                 m_axis_tlast,  // run_end
	output logic [0:0]                           m_axis_tuser,  // frame_end
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [c3mb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c3mb_pkg::ROW_COEF_W-1:0]      cfg_data
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [c3mb_pkg::ROW_COEF_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [11:0] cfg_w_q;
	logic [12:0] cfg_h_q;
	logic        cfg_color_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] act_w_q, pend_w_q;
	logic [HW-1:0] act_h_q;
	logic          act_color_q, pend_valid_q, pend_color_q, pend_h1_q;

	logic          acc, frame_start, r0, row_end;
	logic [WW-1:0] aw;
	logic [HW-1:0] ah;
	logic          ac;
	logic [CW-1:0] c;
	logic [31:0]   wv, hv;
	logic          a_do_col, a_last;
	logic [WW-1:0] a_w;

	logic          s1_v_q, phase_q;
	c3mb_pkg::pix_t pix_s1;
	logic [CW-1:0] c_s1;
	logic          do_col_s1, fill_s1, last_s1, drain_s1, top_mid_s1, bot_mid_s1;
	logic          we_older_s1, color_s1;

	c3mb_pkg::pix_t mem_older [MAX_WIDTH];
	c3mb_pkg::pix_t mem_newer [MAX_WIDTH];
	c3mb_pkg::pix_t rd_older_q, rd_newer_q;
	logic          wr_en;

	c3mb_pkg::win_t win_q, win_next;
	c3mb_pkg::pix_t colv [c3mb_pkg::KDIM];
	logic          need_emit, s1_done, s1_adv;
	logic          req_ready;
	c3mb_pkg::conv_req_t req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q  <= '0;
			coef_mid_q  <= 48'd16777216;
			coef_bot_q  <= '0;
			cfg_w_q     <= 12'd640;
			cfg_h_q     <= 13'd480;
			cfg_color_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				c3mb_pkg::REG_COEF_TOP: coef_top_q  <= cfg_data;
				c3mb_pkg::REG_COEF_MID: coef_mid_q  <= cfg_data;
				c3mb_pkg::REG_COEF_BOT: coef_bot_q  <= cfg_data;
				c3mb_pkg::REG_WIDTH:    cfg_w_q     <= cfg_data[11:0];
				c3mb_pkg::REG_HEIGHT:   cfg_h_q     <= cfg_data[12:0];
				c3mb_pkg::REG_COLOR:    cfg_color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// geometry for the incoming request; latched at the first pixel of a frame
	always_comb begin
		wv = 32'(cfg_w_q);
		hv = 32'(cfg_h_q);
		if (wv == 0) wv = 32'd1;
		else if (wv > 32'(MAX_WIDTH)) wv = 32'(MAX_WIDTH);
		if (hv == 0) hv = 32'd1;
		else if (hv > 32'(MAX_HEIGHT)) hv = 32'(MAX_HEIGHT);
		frame_start = (row_q == '0) && (col_q == '0);
		aw = frame_start ? WW'(wv) : act_w_q;
		ah = frame_start ? HW'(hv) : act_h_q;
		ac = frame_start ? cfg_color_q : act_color_q;
		c  = (32'(col_q) >= 32'(aw)) ? '0 : col_q;
		r0 = (row_q == '0);
		row_end  = (32'(c) == 32'(aw) - 32'd1);
		a_do_col = r0 ? (pend_valid_q && (32'(c) < 32'(pend_w_q))) : 1'b1;
		a_w      = r0 ? pend_w_q : aw;
		a_last   = (32'(c) == 32'(a_w) - 32'd1);
	end

	assign acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			act_w_q      <= WW'(640);
			act_h_q      <= HW'(480);
			act_color_q  <= 1'b1;
			pend_valid_q <= 1'b0;
			pend_w_q     <= WW'(1);
			pend_color_q <= 1'b1;
			pend_h1_q    <= 1'b0;
		end else if (acc) begin
			act_w_q     <= aw;
			act_h_q     <= ah;
			act_color_q <= ac;
			// pending row done, or dropped when row 0 ends first
			if (r0 && ((a_do_col && a_last) || row_end)) pend_valid_q <= 1'b0;
			if (row_end) begin
				col_q <= '0;
				if (32'(row_q) >= 32'(ah) - 32'd1) begin
					pend_valid_q <= 1'b1;
					pend_w_q     <= aw;
					pend_h1_q    <= (ah == HW'(1));
					pend_color_q <= ac;
					row_q        <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= c + CW'(1);
			end
		end
	end

	// s1: one column enters the window; a row-end column takes a second step
	assign need_emit = do_col_s1 && (phase_q || !fill_s1 || last_s1);
	assign s1_done   = phase_q || !(do_col_s1 && last_s1 && !fill_s1);
	assign s1_adv    = s1_v_q && (!need_emit || req_ready);
	assign s_axis_tready = !s1_v_q || (s1_adv && s1_done);
	assign wr_en     = s1_adv && !phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (acc) begin
			s1_v_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (s1_adv && s1_done) begin
			s1_v_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (s1_adv) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= s_axis_tdata;
			c_s1        <= c;
			do_col_s1   <= a_do_col;
			fill_s1     <= (c == '0);
			last_s1     <= a_last;
			drain_s1    <= r0;
			top_mid_s1  <= r0 ? pend_h1_q : (row_q == RW'(1));
			bot_mid_s1  <= r0;
			we_older_s1 <= !r0;
			color_s1    <= r0 ? pend_color_q : ac;
		end
	end

	// line stores; forward a write to the same column issued in this cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_newer[c_s1] <= pix_s1;
			if (we_older_s1) mem_older[c_s1] <= rd_newer_q;
		end
		if (acc) begin
			rd_newer_q <= (wr_en && c_s1 == c) ? pix_s1 : mem_newer[c];
			rd_older_q <= (wr_en && we_older_s1 && c_s1 == c) ? rd_newer_q : mem_older[c];
		end
	end

	always_comb begin
		colv[0] = top_mid_s1 ? rd_newer_q : rd_older_q;
		colv[1] = rd_newer_q;
		colv[2] = bot_mid_s1 ? rd_newer_q : pix_s1;
		for (int r = 0; r < c3mb_pkg::KDIM; r++) begin
			for (int k = 0; k < c3mb_pkg::KDIM; k++) begin
				if ((fill_s1 && !phase_q) || k == c3mb_pkg::KDIM - 1) begin
					win_next[r*c3mb_pkg::KDIM+k] = colv[r];
				end else begin
					win_next[r*c3mb_pkg::KDIM+k] = win_q[r*c3mb_pkg::KDIM+k+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv && do_col_s1) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		req.win       = win_next;
		req.color     = color_s1;
		req.run_end   = phase_q || !(last_s1 && !fill_s1);
		req.frame_end = drain_s1 && last_s1 && (phase_q || fill_s1);
	end

	c3mb_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.coef_top      (coef_top_q),
		.coef_mid      (coef_mid_q),
		.coef_bot      (coef_bot_q),
		.req_valid     (s1_v_q && need_emit),
		.req_ready     (req_ready),
		.req           (req),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);
endmodule
